[hdl/fsa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsa_pkg
// Shared types, sizes and codes of the frame stack arena allocator.
// ---------------------------------------------------------------------------
package fsa_pkg;

    // Alignment must stay a power of two: rounding is done with a mask.
    localparam int unsigned ALIGN_BYTES     = 16;
    localparam int unsigned FRAME_HDR_BYTES = 16;
    localparam int unsigned BLOCK_HDR_BYTES = 32;
    localparam int unsigned HEAD_HDR_BYTES  = 48;
    localparam int unsigned MAX_BLOCKS      = 8;
    localparam int unsigned MAX_FRAMES      = 64;

    localparam int unsigned FRM_SZ = ((FRAME_HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                     * ALIGN_BYTES;
    localparam int unsigned BLK_SZ = ((BLOCK_HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                     * ALIGN_BYTES;
    localparam int unsigned HED_SZ = ((HEAD_HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                     * ALIGN_BYTES;
    localparam int unsigned FIRST_USED = HED_SZ + BLK_SZ + FRM_SZ;

    localparam int unsigned BLK_AW = $clog2(MAX_BLOCKS);
    localparam int unsigned FRM_AW = $clog2(MAX_FRAMES);
    localparam int unsigned CNT_W  = BLK_AW + 1;
    localparam int unsigned DEP_W  = FRM_AW + 1;
    localparam int unsigned FADR_W = BLK_AW + FRM_AW;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_PUSH    = 2'd1;
    localparam logic [1:0] KIND_POP     = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_LIMIT  = 3'd3;
    localparam logic [2:0] ST_SLOT   = 3'd4;
    localparam logic [2:0] ST_CNT    = 3'd5;
    localparam logic [2:0] ST_HALTED = 3'd6;
    localparam logic [2:0] ST_BADCFG = 3'd7;

    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_TOTAL_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] request_size;
    } fsa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_address;
        logic [2:0]  block_index;
        logic [31:0] byte_offset;
        logic [31:0] bytes_used;
        logic [31:0] bytes_reserved;
        logic [31:0] overhead_bytes;
    } fsa_out_t;

    // Block record; the top frame mark is kept here, the marks below it in frame memory.
    typedef struct packed {
        logic [31:0]      total;
        logic [31:0]      used;
        logic [DEP_W-1:0] depth;
        logic [31:0]      top_off;
        logic [15:0]      top_cnt;
    } fsa_blk_t;

    typedef struct packed {
        logic [31:0] off;
        logic [15:0] cnt;
    } fsa_frm_t;

endpackage

[hdl/fsa_block_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsa_block_mem
// Block record memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fsa_block_mem
    import fsa_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [BLK_AW-1:0] wr_addr,
    input  fsa_blk_t          wr_data,
    input  logic [BLK_AW-1:0] rd_addr,
    output fsa_blk_t          rd_data
);

    fsa_blk_t mem [MAX_BLOCKS];
    fsa_blk_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/fsa_frame_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsa_frame_mem
// Frame mark memory for the marks below each block's top mark.
// ---------------------------------------------------------------------------
module fsa_frame_mem
    import fsa_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [FADR_W-1:0] wr_addr,
    input  fsa_frm_t          wr_data,
    input  logic [FADR_W-1:0] rd_addr,
    output fsa_frm_t          rd_data
);

    fsa_frm_t mem [MAX_BLOCKS * MAX_FRAMES];
    fsa_frm_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/frame_stack_arena_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_stack_arena_allocator
// Bump-pointer arena over up to eight blocks with per-block frame mark stacks.
// ---------------------------------------------------------------------------
// Requests enter on s_valid/s_ready (kind, request_size); each gives exactly
// one result on m_valid/m_ready (status, address, byte totals).
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// and take effect at the next restart request.
// Restart and rejected requests go from idle straight to the done state. Alloc,
// push and pop walk the block records in block memory, a read state and an
// evaluate-and-write-back state per block; a pop that drops a mark adds a
// state for the frame memory read. Push runs a check pass and an update pass;
// appending a block adds the append and new-block states.
// One request is in flight at a time; s_ready is high only in the idle state.
// The result register frees the input side: a new request is taken while the
// last result still waits for m_ready. A stalled receiver holds the finished
// result in the final state until the register frees.
// After reset the arena is halted: every request but restart gives status
// halted until a restart with a valid configuration succeeds.
// ---------------------------------------------------------------------------
module frame_stack_arena_allocator
    import fsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  fsa_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output fsa_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_EV     = 7'b0000100,
        S_FEV    = 7'b0001000,
        S_APPEND = 7'b0010000,
        S_NEWBLK = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        OP_ALLOC = 4'b0001,
        OP_PUSH  = 4'b0010,
        OP_MARK  = 4'b0100,
        OP_POP   = 4'b1000
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [31:0] cfg_default_reg, cfg_limit_reg;
    logic [31:0] init_up_reg, init_up_next;
    logic [31:0] limit_up_reg, limit_up_next;
    logic        err_reg, err_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] sum_used_reg, sum_used_next;
    logic [31:0] sum_res_reg, sum_res_next;
    logic [31:0] sum_ovh_reg, sum_ovh_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pass_reg, pass_next;
    logic [32:0]      up_reg, up_next;
    logic             pick_found_reg, pick_found_next;
    logic [BLK_AW-1:0] pick_reg, pick_next;
    logic [DEP_W-1:0] pick_depth_reg, pick_depth_next;
    logic             err5_reg, err5_next;
    fsa_blk_t         cur_reg, cur_next;

    logic [2:0]  res_st_reg, res_st_next;
    logic        res_has_reg, res_has_next;
    logic [2:0]  res_blk_reg, res_blk_next;
    logic [31:0] res_off_reg, res_off_next;

    logic     m_valid_reg, m_valid_next;
    fsa_out_t m_data_reg, m_data_next;

    logic              bw_en;
    logic [BLK_AW-1:0] bw_addr;
    fsa_blk_t          bw_data;
    fsa_blk_t          brd;
    logic              fw_en;
    logic [FADR_W-1:0] fw_addr;
    fsa_frm_t          fw_data;
    logic [FADR_W-1:0] frd_addr;
    fsa_frm_t          frd;

    fsa_block_mem u_blk (
        .aclk    (aclk),
        .wr_en   (bw_en),
        .wr_addr (bw_addr),
        .wr_data (bw_data),
        .rd_addr (idx_reg[BLK_AW-1:0]),
        .rd_data (brd)
    );

    fsa_frame_mem u_frm (
        .aclk    (aclk),
        .wr_en   (fw_en),
        .wr_addr (fw_addr),
        .wr_data (fw_data),
        .rd_addr (frd_addr),
        .rd_data (frd)
    );

    // Combinational helpers
    logic [31:0]       raw;
    logic [32:0]       up_in;
    logic [32:0]       chunk;
    logic [32:0]       need;
    logic [31:0]       room;
    logic [BLK_AW-1:0] b;
    logic [CNT_W-1:0]  idx_inc;
    logic              last;
    logic [31:0]       diff;
    logic [31:0]       new_total;

    assign raw     = s_data.request_size;
    assign up_in   = ({1'b0, raw} + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
    assign chunk   = up_reg + 33'(FRM_SZ);
    assign need    = chunk + 33'(BLK_SZ + FRM_SZ);
    assign room    = brd.total - brd.used;
    assign b       = idx_reg[BLK_AW-1:0];
    assign idx_inc = idx_reg + 1'b1;
    assign last    = (idx_inc == count_reg);
    assign diff    = cur_reg.top_off - frd.off;
    assign new_total = (init_up_reg >= need[31:0]) ? init_up_reg : need[31:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        init_up_next    = init_up_reg;
        limit_up_next   = limit_up_reg;
        err_next        = err_reg;
        count_next      = count_reg;
        sum_used_next   = sum_used_reg;
        sum_res_next    = sum_res_reg;
        sum_ovh_next    = sum_ovh_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        up_next         = up_reg;
        pick_found_next = pick_found_reg;
        pick_next       = pick_reg;
        pick_depth_next = pick_depth_reg;
        err5_next       = err5_reg;
        cur_next        = cur_reg;
        res_st_next     = res_st_reg;
        res_has_next    = res_has_reg;
        res_blk_next    = res_blk_reg;
        res_off_next    = res_off_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        bw_en           = 1'b0;
        bw_addr         = b;
        bw_data         = brd;
        fw_en           = 1'b0;
        fw_addr         = {b, brd.depth[FRM_AW-1:0] - 1'b1};
        fw_data         = '{off: brd.top_off, cnt: brd.top_cnt};
        frd_addr        = {b, brd.depth[FRM_AW-1:0] - FRM_AW'(2)};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_st_next  = ST_OK;
                    res_has_next = 1'b0;
                    res_blk_next = '0;
                    res_off_next = '0;
                    up_next      = up_in;
                    idx_next     = '0;
                    pass_next    = 1'b0;
                    pick_found_next = 1'b0;
                    err5_next    = 1'b0;
                    state_next   = S_DONE;
                    if (s_data.kind == KIND_RESTART) begin
                        err_next      = 1'b1;
                        count_next    = '0;
                        sum_used_next = '0;
                        sum_res_next  = '0;
                        sum_ovh_next  = '0;
                        init_up_next  = '0;
                        limit_up_next = '0;
                        if (cfg_default_reg < 32'(FIRST_USED) ||
                            cfg_default_reg > cfg_limit_reg ||
                            cfg_limit_reg > ~32'(ALIGN_BYTES - 1)) begin
                            res_st_next = ST_BADCFG;
                        end else begin
                            init_up_next  = (cfg_default_reg + 32'(ALIGN_BYTES - 1))
                                            & ~32'(ALIGN_BYTES - 1);
                            limit_up_next = (cfg_limit_reg + 32'(ALIGN_BYTES - 1))
                                            & ~32'(ALIGN_BYTES - 1);
                            count_next    = CNT_W'(1);
                            sum_used_next = 32'(FIRST_USED);
                            sum_res_next  = init_up_next;
                            sum_ovh_next  = 32'(FIRST_USED);
                            err_next      = 1'b0;
                            bw_en         = 1'b1;
                            bw_addr       = '0;
                            bw_data       = '{total: init_up_next, used: 32'(FIRST_USED),
                                              depth: DEP_W'(1),
                                              top_off: 32'(HED_SZ + BLK_SZ),
                                              top_cnt: 16'd0};
                        end
                    end else if (err_reg) begin
                        res_st_next = ST_HALTED;
                    end else if (s_data.kind == KIND_POP) begin
                        op_next    = OP_POP;
                        state_next = S_RD;
                    end else if (raw[31] || (s_data.kind == KIND_ALLOC && raw == '0)) begin
                        res_st_next = ST_UNDER;
                    end else if (s_data.kind == KIND_PUSH && raw == '0) begin
                        op_next    = OP_MARK;
                        state_next = S_RD;
                    end else if ({1'b0, up_in} + 34'(2 * FRM_SZ + BLK_SZ) >
                                 34'h0_FFFF_FFFF) begin
                        res_st_next = ST_OVER;
                    end else if (s_data.kind == KIND_ALLOC) begin
                        if ({1'b0, sum_used_reg} + up_in > {1'b0, limit_up_reg}) begin
                            res_st_next = ST_LIMIT;
                        end else begin
                            op_next    = OP_ALLOC;
                            state_next = S_RD;
                        end
                    end else begin
                        if ({1'b0, sum_used_reg} + up_in + 33'(FRM_SZ) >
                            {1'b0, limit_up_reg}) begin
                            res_st_next = ST_LIMIT;
                        end else begin
                            op_next    = OP_PUSH;
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_RD: begin
                state_next = S_EV;
            end

            S_EV: begin
                // Advance to the next block by default
                idx_next   = idx_inc;
                state_next = S_RD;
                case (op_reg)
                    OP_ALLOC: begin
                        if (brd.top_cnt == '0 && up_reg <= {1'b0, room}) begin
                            bw_en           = 1'b1;
                            bw_data.top_off = brd.top_off + up_reg[31:0];
                            bw_data.used    = brd.used + up_reg[31:0];
                            sum_used_next   = sum_used_reg + up_reg[31:0];
                            res_has_next    = 1'b1;
                            res_blk_next    = 3'(b);
                            res_off_next    = brd.top_off;
                            state_next      = S_DONE;
                        end else if (brd.top_cnt != '0 && chunk <= {1'b0, room}) begin
                            state_next = S_DONE;
                            if (brd.depth >= DEP_W'(MAX_FRAMES)) begin
                                res_st_next = ST_SLOT;
                            end else begin
                                // Drop one pending count, then lay a real mark
                                fw_en           = 1'b1;
                                fw_data.cnt     = brd.top_cnt - 1'b1;
                                bw_en           = 1'b1;
                                bw_data.top_off = brd.top_off + chunk[31:0];
                                bw_data.top_cnt = '0;
                                bw_data.depth   = brd.depth + 1'b1;
                                bw_data.used    = brd.used + chunk[31:0];
                                sum_used_next   = sum_used_reg + chunk[31:0];
                                sum_ovh_next    = sum_ovh_reg + 32'(FRM_SZ);
                                res_has_next    = 1'b1;
                                res_blk_next    = 3'(b);
                                res_off_next    = brd.top_off + 32'(FRM_SZ);
                            end
                        end else if (last) begin
                            state_next = S_APPEND;
                        end
                    end
                    OP_PUSH: begin
                        if (!pass_reg) begin
                            if (chunk <= {1'b0, room} && !pick_found_reg) begin
                                pick_found_next = 1'b1;
                                pick_next       = b;
                                pick_depth_next = brd.depth;
                            end else if (brd.top_cnt == CNT_MAX) begin
                                err5_next = 1'b1;
                            end
                            if (last) begin
                                idx_next = '0;
                                if (err5_next) begin
                                    res_st_next = ST_CNT;
                                    state_next  = S_DONE;
                                end else if (pick_found_next) begin
                                    if (pick_depth_next >= DEP_W'(MAX_FRAMES)) begin
                                        res_st_next = ST_SLOT;
                                        state_next  = S_DONE;
                                    end else begin
                                        pass_next = 1'b1;
                                    end
                                end else begin
                                    state_next = S_APPEND;
                                end
                            end
                        end else begin
                            bw_en = 1'b1;
                            if (pick_found_reg && b == pick_reg) begin
                                fw_en           = 1'b1;
                                bw_data.top_off = brd.top_off + chunk[31:0];
                                bw_data.top_cnt = '0;
                                bw_data.depth   = brd.depth + 1'b1;
                                bw_data.used    = brd.used + chunk[31:0];
                                sum_used_next   = sum_used_reg + chunk[31:0];
                                sum_ovh_next    = sum_ovh_reg + 32'(FRM_SZ);
                                res_has_next    = 1'b1;
                                res_blk_next    = 3'(b);
                                res_off_next    = brd.top_off + 32'(FRM_SZ);
                            end else begin
                                bw_data.top_cnt = brd.top_cnt + 1'b1;
                            end
                            if (last) begin
                                state_next = pick_found_reg ? S_DONE : S_NEWBLK;
                            end
                        end
                    end
                    OP_MARK: begin
                        if (!pass_reg) begin
                            if (brd.top_cnt == CNT_MAX) begin
                                err5_next = 1'b1;
                            end
                            if (last) begin
                                idx_next = '0;
                                if (err5_next) begin
                                    res_st_next = ST_CNT;
                                    state_next  = S_DONE;
                                end else begin
                                    pass_next = 1'b1;
                                end
                            end
                        end else begin
                            bw_en           = 1'b1;
                            bw_data.top_cnt = brd.top_cnt + 1'b1;
                            if (last) begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    OP_POP: begin
                        if (brd.top_cnt != '0) begin
                            bw_en           = 1'b1;
                            bw_data.top_cnt = brd.top_cnt - 1'b1;
                            if (last) begin
                                state_next = S_DONE;
                            end
                        end else if (brd.depth > DEP_W'(1)) begin
                            // Hold the block and fetch the mark below the top
                            cur_next   = brd;
                            idx_next   = idx_reg;
                            state_next = S_FEV;
                        end else if (last) begin
                            state_next = S_DONE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end

            S_FEV: begin
                bw_en           = 1'b1;
                bw_data         = cur_reg;
                bw_data.top_off = frd.off;
                bw_data.top_cnt = frd.cnt;
                bw_data.depth   = cur_reg.depth - 1'b1;
                bw_data.used    = cur_reg.used - diff;
                sum_used_next   = sum_used_reg - diff;
                sum_ovh_next    = sum_ovh_reg - 32'(FRM_SZ);
                idx_next        = idx_inc;
                state_next      = last ? S_DONE : S_RD;
            end

            S_APPEND: begin
                if ({1'b0, need} + {2'b00, sum_res_reg} > {2'b00, limit_up_reg}) begin
                    res_st_next = ST_LIMIT;
                    state_next  = S_DONE;
                end else if (count_reg >= CNT_W'(MAX_BLOCKS)) begin
                    res_st_next = ST_SLOT;
                    state_next  = S_DONE;
                end else if (op_reg == OP_PUSH) begin
                    // Count the push in every existing block before appending
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    state_next = S_RD;
                end else begin
                    state_next = S_NEWBLK;
                end
            end

            S_NEWBLK: begin
                bw_en         = 1'b1;
                bw_addr       = count_reg[BLK_AW-1:0];
                bw_data       = '{total: new_total, used: need[31:0], depth: DEP_W'(2),
                                  top_off: 32'(BLK_SZ) + chunk[31:0], top_cnt: 16'd0};
                fw_en         = 1'b1;
                fw_addr       = {count_reg[BLK_AW-1:0], FRM_AW'(0)};
                fw_data       = '{off: 32'(BLK_SZ), cnt: 16'd0};
                count_next    = count_reg + 1'b1;
                sum_used_next = sum_used_reg + need[31:0];
                sum_res_next  = sum_res_reg + new_total;
                sum_ovh_next  = sum_ovh_reg + 32'(BLK_SZ + 2 * FRM_SZ);
                res_has_next  = 1'b1;
                res_blk_next  = 3'(count_reg[BLK_AW-1:0]);
                res_off_next  = 32'(BLK_SZ + FRM_SZ);
                state_next    = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: res_st_reg, has_address: res_has_reg,
                                     block_index: res_blk_reg, byte_offset: res_off_reg,
                                     bytes_used: sum_used_reg, bytes_reserved: sum_res_reg,
                                     overhead_bytes: sum_ovh_reg};
                    if (res_st_reg != ST_OK && res_st_reg != ST_HALTED) begin
                        err_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_ALLOC;
            cfg_default_reg <= 32'd4096;
            cfg_limit_reg   <= 32'd65536;
            init_up_reg     <= '0;
            limit_up_reg    <= '0;
            err_reg         <= 1'b1;
            count_reg       <= '0;
            sum_used_reg    <= '0;
            sum_res_reg     <= '0;
            sum_ovh_reg     <= '0;
            idx_reg         <= '0;
            pass_reg        <= 1'b0;
            pick_found_reg  <= 1'b0;
            err5_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            init_up_reg    <= init_up_next;
            limit_up_reg   <= limit_up_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            sum_used_reg   <= sum_used_next;
            sum_res_reg    <= sum_res_next;
            sum_ovh_reg    <= sum_ovh_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            pick_found_reg <= pick_found_next;
            err5_reg       <= err5_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLOCK_SIZE:  cfg_default_reg <= cfg_wr_data;
                    REG_TOTAL_LIMIT: cfg_limit_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        up_reg         <= up_next;
        pick_reg       <= pick_next;
        pick_depth_reg <= pick_depth_next;
        cur_reg        <= cur_next;
        res_st_reg     <= res_st_next;
        res_has_reg    <= res_has_next;
        res_blk_reg    <= res_blk_next;
        res_off_reg    <= res_off_next;
        m_data_reg     <= m_data_next;
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame stack arena allocator.
// ---------------------------------------------------------------------------
// Drives requests through a directed table and then random request streams,
// predicts every result with a behavioral arena model, and compares results
// field by field. Idle bursts on both sides, one long receiver hold-off and
// drain pauses exercise the handshakes. Configuration changes between
// phases, with restarts, walk through default, extreme and bad settings.
// ---------------------------------------------------------------------------
module tb_top;
    import fsa_pkg::*;

    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic       fixed;
        logic [2:0] status;
    } typed_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    fsa_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    fsa_out_t    m_data;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wr_data;

    // typed-in status that travels alongside each request
    logic        s_fixed;
    logic [2:0]  s_typed;

    frame_stack_arena_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- arena predictor ----------------
    longint unsigned cfg_default, cfg_limit;
    bit              halted;
    int unsigned     nblk;
    longint unsigned blk_total [MAX_BLOCKS];
    longint unsigned blk_used  [MAX_BLOCKS];
    int unsigned     blk_depth [MAX_BLOCKS];
    longint unsigned mark_off  [MAX_BLOCKS*MAX_FRAMES];
    int unsigned     mark_cnt  [MAX_BLOCKS*MAX_FRAMES];
    longint unsigned tot_used, tot_resv, tot_ovh, init_up, limit_up;

    fsa_out_t expected_results[$];
    typed_t   typed_q[$];

    int  errors;
    int  n_results;
    int  st_seen [8];
    bit  hold_off;
    bit  no_idle;
    longint unsigned cycle_cnt;

    function automatic longint unsigned align_up(longint unsigned x);
        return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic int unsigned top_idx(int unsigned b);
        return b * MAX_FRAMES + blk_depth[b] - 1;
    endfunction

    function automatic void clear_arena();
        nblk = 0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_total[i] = 0; blk_used[i] = 0; blk_depth[i] = 0;
        end
        for (int i = 0; i < MAX_BLOCKS*MAX_FRAMES; i++) begin
            mark_off[i] = 0; mark_cnt[i] = 0;
        end
        tot_used = 0; tot_resv = 0; tot_ovh = 0; init_up = 0; limit_up = 0;
    endfunction

    function automatic fsa_out_t make_result(logic [2:0] st, bit has, int unsigned b,
                                             longint unsigned off);
        fsa_out_t r;
        if (st != ST_OK && st != ST_HALTED) halted = 1'b1;
        r.status         = st;
        r.has_address    = has;
        r.block_index    = has ? b[2:0] : 3'd0;
        r.byte_offset    = has ? off[31:0] : 32'd0;
        r.bytes_used     = tot_used[31:0];
        r.bytes_reserved = tot_resv[31:0];
        r.overhead_bytes = tot_ovh[31:0];
        return r;
    endfunction

    function automatic logic [2:0] add_block(longint unsigned chunk);
        longint unsigned need;
        int unsigned b;
        need = chunk + BLK_SZ + FRM_SZ;
        b = nblk;
        if (need + tot_resv > limit_up) return ST_LIMIT;
        if (b >= MAX_BLOCKS) return ST_SLOT;
        blk_total[b] = (init_up >= need) ? init_up : need;
        blk_used[b]  = need;
        blk_depth[b] = 2;
        mark_off[b*MAX_FRAMES] = BLK_SZ;
        mark_cnt[b*MAX_FRAMES] = 0;
        mark_off[b*MAX_FRAMES+1] = BLK_SZ + chunk;
        mark_cnt[b*MAX_FRAMES+1] = 0;
        nblk = b + 1;
        tot_used += need;
        tot_resv += blk_total[b];
        tot_ovh  += BLK_SZ + 2 * FRM_SZ;
        return ST_OK;
    endfunction

    function automatic longint unsigned lay_mark(int unsigned b, longint unsigned chunk);
        int unsigned t;
        longint unsigned base;
        t = top_idx(b);
        base = mark_off[t];
        mark_off[t+1] = base + chunk;
        mark_cnt[t+1] = 0;
        blk_depth[b]++;
        blk_used[b] += chunk;
        tot_used += chunk;
        tot_ovh  += FRM_SZ;
        return base + FRM_SZ;
    endfunction

    function automatic fsa_out_t arena_restart();
        clear_arena();
        halted = 1'b1;
        if (cfg_default < FIRST_USED || cfg_default > cfg_limit || align_up(cfg_limit) > M32)
            return make_result(ST_BADCFG, 0, 0, 0);
        init_up = align_up(cfg_default);
        limit_up = align_up(cfg_limit);
        nblk = 1;
        blk_total[0] = init_up;
        blk_used[0] = FIRST_USED;
        blk_depth[0] = 1;
        mark_off[0] = HED_SZ + BLK_SZ;
        mark_cnt[0] = 0;
        tot_used = FIRST_USED; tot_resv = init_up; tot_ovh = FIRST_USED;
        halted = 1'b0;
        return make_result(ST_OK, 0, 0, 0);
    endfunction

    function automatic fsa_out_t arena_alloc(longint unsigned up);
        int unsigned t;
        longint unsigned room, off;
        logic [2:0] st;
        if (tot_used + up > limit_up) return make_result(ST_LIMIT, 0, 0, 0);
        for (int unsigned b = 0; b < nblk; b++) begin
            t = top_idx(b);
            room = blk_total[b] - blk_used[b];
            if (mark_cnt[t] == 0 && up <= room) begin
                off = mark_off[t];
                mark_off[t] = off + up;
                blk_used[b] += up;
                tot_used += up;
                return make_result(ST_OK, 1, b, off);
            end
            if (mark_cnt[t] > 0 && up + FRM_SZ <= room) begin
                if (blk_depth[b] >= MAX_FRAMES) return make_result(ST_SLOT, 0, 0, 0);
                mark_cnt[t]--;
                off = lay_mark(b, up + FRM_SZ);
                return make_result(ST_OK, 1, b, off);
            end
        end
        st = add_block(up + FRM_SZ);
        if (st != ST_OK) return make_result(st, 0, 0, 0);
        return make_result(ST_OK, 1, nblk - 1, BLK_SZ + FRM_SZ);
    endfunction

    function automatic fsa_out_t arena_push(longint unsigned up);
        longint unsigned chunk, off;
        int unsigned n, pick;
        logic [2:0] st;
        chunk = up + FRM_SZ;
        n = nblk;
        pick = MAX_BLOCKS;
        if (tot_used + chunk > limit_up) return make_result(ST_LIMIT, 0, 0, 0);
        for (int unsigned b = 0; b < n; b++)
            if (pick == MAX_BLOCKS && chunk <= blk_total[b] - blk_used[b]) pick = b;
        for (int unsigned b = 0; b < n; b++)
            if (b != pick && mark_cnt[top_idx(b)] >= CNT_MAX)
                return make_result(ST_CNT, 0, 0, 0);
        if (pick < n) begin
            if (blk_depth[pick] >= MAX_FRAMES) return make_result(ST_SLOT, 0, 0, 0);
            for (int unsigned b = 0; b < n; b++)
                if (b != pick) mark_cnt[top_idx(b)]++;
            off = lay_mark(pick, chunk);
            return make_result(ST_OK, 1, pick, off);
        end
        st = add_block(chunk);
        if (st != ST_OK) return make_result(st, 0, 0, 0);
        for (int unsigned b = 0; b < n; b++) mark_cnt[top_idx(b)]++;
        return make_result(ST_OK, 1, n, BLK_SZ + FRM_SZ);
    endfunction

    function automatic fsa_out_t arena_mark();
        for (int unsigned b = 0; b < nblk; b++)
            if (mark_cnt[top_idx(b)] >= CNT_MAX) return make_result(ST_CNT, 0, 0, 0);
        for (int unsigned b = 0; b < nblk; b++) mark_cnt[top_idx(b)]++;
        return make_result(ST_OK, 0, 0, 0);
    endfunction

    function automatic fsa_out_t arena_pop();
        int unsigned t;
        longint unsigned diff;
        for (int unsigned b = 0; b < nblk; b++) begin
            t = top_idx(b);
            if (mark_cnt[t] > 0) begin
                mark_cnt[t]--;
            end else if (blk_depth[b] > 1) begin
                diff = mark_off[t] - mark_off[t-1];
                blk_depth[b]--;
                blk_used[b] -= diff;
                tot_used -= diff;
                tot_ovh -= FRM_SZ;
            end
        end
        return make_result(ST_OK, 0, 0, 0);
    endfunction

    function automatic fsa_out_t arena_step(fsa_in_t req);
        longint unsigned raw, up;
        bit neg;
        raw = longint'(req.request_size) & M32;
        neg = req.request_size[31];
        up = align_up(raw);
        if (req.kind == KIND_RESTART) return arena_restart();
        if (halted) return make_result(ST_HALTED, 0, 0, 0);
        if (req.kind == KIND_POP) return arena_pop();
        if (neg || (req.kind == KIND_ALLOC && raw == 0)) return make_result(ST_UNDER, 0, 0, 0);
        if (req.kind == KIND_PUSH && raw == 0) return arena_mark();
        if (up + 2 * FRM_SZ + BLK_SZ > M32) return make_result(ST_OVER, 0, 0, 0);
        if (req.kind == KIND_ALLOC) return arena_alloc(up);
        return arena_push(up);
    endfunction

    // ---------------- driving ----------------
    // valid stays high from one request to the next unless an idle burst comes
    task automatic send_request(logic [1:0] kind, logic [31:0] size,
                                logic fixed = 1'b0, logic [2:0] status = ST_OK);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.kind <= kind;
        s_data.request_size <= size;
        s_fixed <= fixed;
        s_typed <= status;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // hold requests and let the block empty before touching a register
    task automatic write_reg(logic idx, logic [31:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BLOCK_SIZE) cfg_default = val;
        else cfg_limit = val;
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 80);
            3:       return $urandom_range(1, 8000);
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return KIND_ALLOC;
        if (r < 75) return KIND_PUSH;
        if (r < 97) return KIND_POP;
        return KIND_RESTART;
    endfunction

    // predict at each accepted request, check at each accepted result
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(arena_step(s_data));
            typed_q.push_back('{fixed: s_fixed, status: s_typed});
        end
        if (aresetn && m_valid && m_ready) begin
            fsa_out_t e;
            typed_t   t;
            if (expected_results.size() == 0) begin
                $error("result with no request pending: status %0d", m_data.status);
                errors++;
            end else begin
                e = expected_results.pop_front();
                t = typed_q.pop_front();
                n_results++;
                st_seen[m_data.status]++;
                if (t.fixed && m_data.status !== t.status) begin
                    $error("status (table): expected %0d, got %0d", t.status,
                           m_data.status); errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_data.status); errors++;
                end
                if (m_data.has_address !== e.has_address) begin
                    $error("has_address: expected %0d, got %0d", e.has_address,
                           m_data.has_address); errors++;
                end
                if (m_data.block_index !== e.block_index) begin
                    $error("block_index: expected %0d, got %0d", e.block_index,
                           m_data.block_index); errors++;
                end
                if (m_data.byte_offset !== e.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d", e.byte_offset,
                           m_data.byte_offset); errors++;
                end
                if (m_data.bytes_used !== e.bytes_used) begin
                    $error("bytes_used: expected %0d, got %0d", e.bytes_used,
                           m_data.bytes_used); errors++;
                end
                if (m_data.bytes_reserved !== e.bytes_reserved) begin
                    $error("bytes_reserved: expected %0d, got %0d", e.bytes_reserved,
                           m_data.bytes_reserved); errors++;
                end
                if (m_data.overhead_bytes !== e.overhead_bytes) begin
                    $error("overhead_bytes: expected %0d, got %0d", e.overhead_bytes,
                           m_data.overhead_bytes); errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT_CYCLES) begin
                $display("frame_stack_arena_allocator test failed");
                $finish;
            end
        end
    end

    // directed rows: kind, size, and a typed-in status where it is obvious
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] size;
        bit          fixed;
        logic [2:0]  status;
    } dir_row_t;

    dir_row_t dir_table[] = '{
        '{KIND_ALLOC,   32'd16,          1, ST_HALTED},
        '{KIND_POP,     32'd0,           1, ST_HALTED},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_ALLOC,   32'd0,           1, ST_UNDER},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_PUSH,    32'h8000_0000,   1, ST_UNDER},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_ALLOC,   32'hFFFF_FFFF,   1, ST_UNDER},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_ALLOC,   32'h7FFF_FFFF,   1, ST_LIMIT},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_ALLOC,   32'h7FFF_FFF0,   1, ST_LIMIT},
        '{KIND_RESTART, 32'd0,           1, ST_OK},
        '{KIND_ALLOC,   32'd1,           0, ST_OK},
        '{KIND_ALLOC,   32'd100,         0, ST_OK},
        '{KIND_PUSH,    32'd0,           0, ST_OK},
        '{KIND_PUSH,    32'd40,          0, ST_OK},
        '{KIND_ALLOC,   32'd5000,        0, ST_OK},
        '{KIND_PUSH,    32'd3000,        0, ST_OK},
        '{KIND_ALLOC,   32'd64,          0, ST_OK},
        '{KIND_POP,     32'd0,           0, ST_OK},
        '{KIND_POP,     32'd0,           0, ST_OK},
        '{KIND_POP,     32'd0,           0, ST_OK},
        '{KIND_ALLOC,   32'd70000,       1, ST_LIMIT},
        '{KIND_ALLOC,   32'd16,          1, ST_HALTED}
    };

    task automatic random_phase(int count);
        logic [1:0] k;
        for (int i = 0; i < count; i++) begin
            k = rand_kind();
            send_request(k, rand_size());
            // recover quickly so most requests reach a live arena
            if (halted && $urandom_range(0, 3) != 0) send_request(KIND_RESTART, $urandom);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_fixed = 1'b0;
        s_typed = ST_OK;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BLOCK_SIZE;
        cfg_wr_data = '0;
        errors = 0; n_results = 0; hold_off = 1'b0; no_idle = 1'b0;
        for (int i = 0; i < 8; i++) st_seen[i] = 0;
        cfg_default = 4096; cfg_limit = 65536;
        clear_arena();
        halted = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            send_request(dir_table[i].kind, dir_table[i].size,
                         dir_table[i].fixed, dir_table[i].status);
        end
        wait_drained();

        // bad configurations, then extremes
        write_reg(REG_BLOCK_SIZE, 32'd16);
        write_reg(REG_TOTAL_LIMIT, 32'hFFFF_FFFF);
        send_request(KIND_RESTART, 32'd0);
        send_request(KIND_PUSH, 32'd0);
        write_reg(REG_BLOCK_SIZE, FIRST_USED);
        wait_drained();
        send_request(KIND_RESTART, 32'd0);
        write_reg(REG_TOTAL_LIMIT, 32'hFFFF_FFF0);
        wait_drained();
        send_request(KIND_RESTART, 32'd0);
        random_phase(100);
        wait_drained();

        // small blocks and tight limit: many blocks, slot and limit errors
        write_reg(REG_BLOCK_SIZE, 32'd200);
        write_reg(REG_TOTAL_LIMIT, 32'd6000);
        send_request(KIND_RESTART, 32'd0);
        random_phase(110);

        // drain pause, then long receiver hold-off while requests keep coming
        wait_drained();
        hold_off = 1'b1;
        random_phase(30);
        wait_drained();

        write_reg(REG_BLOCK_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_TOTAL_LIMIT, 32'hFFFF_FFFF);
        send_request(KIND_RESTART, 32'd0);
        write_reg(REG_BLOCK_SIZE, 32'd4096);
        write_reg(REG_TOTAL_LIMIT, 32'd65536);
        wait_drained();
        send_request(KIND_RESTART, 32'd0);
        random_phase(140);

        // empty marks pile counters on every block, then pops unwind them
        wait_drained();
        write_reg(REG_BLOCK_SIZE, 32'd128);
        write_reg(REG_TOTAL_LIMIT, 32'd1000000);
        send_request(KIND_RESTART, 32'd0);
        no_idle = 1'b1;
        send_request(KIND_PUSH, 32'd8);
        for (int i = 0; i < 20; i++) send_request(KIND_PUSH, 32'd0);
        for (int i = 0; i < 20; i++) send_request(KIND_POP, 32'd0);
        random_phase(100);

        wait_drained();
        if (expected_results.size() != 0) errors++;
        $display("covered %0d results: ok %0d, underflow %0d, overflow %0d, limit %0d,",
                 n_results, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
        $display("slot %0d, counter %0d, halted %0d, bad config %0d",
                 st_seen[4], st_seen[5], st_seen[6], st_seen[7]);
        if (errors == 0) begin
            $display("frame_stack_arena_allocator test passed");
        end else begin
            $display("frame_stack_arena_allocator test failed");
        end
        $finish;
    end

endmodule
